### rtl/utf2l_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf2l_pkg
// shared constants, types and the lead byte classifier for the transcoder
// ----------------------------------------------------------------------------
package utf2l_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register index lives at paddr[2] (one register, 4-byte stride)
  localparam logic REG_REPLACEMENT = 1'b0;
  localparam logic [7:0] REPLACEMENT_RESET = 8'h3f;

  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // results of one request, lead result in slot 0
  typedef struct packed {
    logic [1:0]      cnt;
    logic            fin;
    logic [2:0][7:0] bytes;
  } res_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] n;
    n = LEN_ONE;
    if ((c & 8'he0) == 8'hc0) begin
      n = LEN_TWO;
    end else if ((c & 8'hf0) == 8'he0) begin
      n = LEN_THREE;
    end else if ((c & 8'hf8) == 8'hf0) begin
      n = LEN_FOUR;
    end
    return n;
  endfunction

endpackage

### rtl/utf8_to_latin1_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_latin1_stream
// streaming UTF-8 to Latin-1 transcoder with a replacement byte register
// ----------------------------------------------------------------------------
// throughput: one byte per cycle while the output does not stall; a final
//   byte that flushes an unfinished sequence can give up to 3 results, and
//   the input register holds while the single result register drains them
// reset: synchronous, clears pipeline valids and the held count,
//   replacement byte returns to '?'
module utf8_to_latin1_stream (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        is_final,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        run_last,
  output logic                        text_end,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utf2l_pkg::ADDR_W-1:0] paddr,
  input  logic [utf2l_pkg::DATA_W-1:0] pwdata,
  output logic [utf2l_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import utf2l_pkg::*;

  logic [7:0] repl;
  logic       buf_free;
  logic       res_load;
  res_t       res;

  utf2l_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .repl    (repl)
  );

  utf2l_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .is_final (is_final),
    .repl     (repl),
    .buf_free (buf_free),
    .res_load (res_load),
    .res      (res)
  );

  utf2l_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .buf_free  (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule

### rtl/utf2l_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf2l_cfg
// register port holding the replacement byte
// ----------------------------------------------------------------------------
module utf2l_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [utf2l_pkg::ADDR_W-1:0] paddr,
  input  logic [utf2l_pkg::DATA_W-1:0] pwdata,
  output logic [utf2l_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  repl
);
  import utf2l_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl <= REPLACEMENT_RESET;
    end else if (wr && paddr[2] == REG_REPLACEMENT) begin
      repl <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_REPLACEMENT) begin
      prdata = {{(DATA_W-8){1'b0}}, repl};
    end
  end

endmodule

### rtl/utf2l_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf2l_decode
// input register, pending sequence store and single-pass decode of one request
// ----------------------------------------------------------------------------
module utf2l_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            is_final,
  input  logic [7:0]      repl,
  input  logic            buf_free,
  output logic            res_load,
  output utf2l_pkg::res_t res
);
  import utf2l_pkg::*;

  logic            a_valid;
  logic [7:0]      a_byte;
  logic            a_fin;
  logic            a_move;
  logic [7:0]      held [3];
  logic [1:0]      held_count;
  logic [3:0][7:0] seq;
  logic [2:0]      len;
  logic            hold;

  function automatic logic [7:0] pick(input logic [3:0][7:0] b, input logic [2:0] i);
    return (i < 3'd4) ? b[i[1:0]] : 8'h00;
  endfunction

  // byte string as seen by this request: held bytes then the new byte
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < held_count) begin
        seq[k] = held[k];
      end else if (3'(k) == {1'b0, held_count}) begin
        seq[k] = a_byte;
      end else begin
        seq[k] = 8'h00;
      end
    end
    len  = {1'b0, held_count} + 3'd1;
    hold = (len < seq_len(seq[0])) && !a_fin;
  end

  // walk the string, at most three results
  always_comb begin
    logic [2:0] pos;
    logic [2:0] n;
    logic [7:0] c;
    logic [7:0] b1;
    logic [7:0] b2;
    pos       = 3'd0;
    n         = LEN_ONE;
    c         = 8'h00;
    b1        = 8'h00;
    b2        = 8'h00;
    res.cnt   = 2'd0;
    res.fin   = a_fin;
    res.bytes = '0;
    for (int r = 0; r < 3; r++) begin
      if (pos < len) begin
        c  = pick(seq, pos);
        b1 = pick(seq, pos + 3'd1);
        b2 = pick(seq, pos + 3'd2);
        n  = seq_len(c);
        if (n == LEN_ONE || pos + n > len) begin
          n = LEN_ONE;
        end
        case (n)
          LEN_TWO:   res.bytes[r] = (c[4:2] == 3'd0) ? {c[1:0], b1[5:0]} : repl;
          LEN_THREE: res.bytes[r] = (c[3:0] == 4'd0 && b1[5:2] == 4'd0) ?
                                    {b1[1:0], b2[5:0]} : repl;
          LEN_FOUR:  res.bytes[r] = repl;
          default:   res.bytes[r] = c;
        endcase
        pos     = pos + n;
        res.cnt = res.cnt + 2'd1;
      end
    end
  end

  assign a_move   = a_valid && (hold || buf_free);
  assign res_load = a_valid && !hold && buf_free;
  assign in_stall = a_valid && !a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_byte <= in_byte;
      a_fin  <= is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (a_move) begin
      held_count <= hold ? len[1:0] : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && hold) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) == held_count) begin
          held[k] <= a_byte;
        end
      end
    end
  end

  // a pending sequence is always shorter than its lead asks for
  a_held_short: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd0 |-> seq_len(held[0]) > {1'b0, held_count})
    else $error("held sequence already complete");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> a_valid && $stable(a_byte) && $stable(a_fin))
    else $error("input register changed while stalled");

endmodule

### rtl/utf2l_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf2l_outbuf
// result register, hands out the results of one request one per cycle unless stalled
// ----------------------------------------------------------------------------
module utf2l_outbuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_load,
  input  utf2l_pkg::res_t res,
  output logic            buf_free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            text_end
);
  import utf2l_pkg::*;

  logic [2:0][7:0] bytes;
  logic [1:0]      rem;
  logic            fin;
  logic            take;

  assign out_valid = rem != 2'd0;
  assign take      = out_valid && !out_stall;
  assign buf_free  = rem == 2'd0 || (rem == 2'd1 && take);
  assign out_byte  = bytes[0];
  assign run_last  = rem == 2'd1;
  assign text_end  = run_last && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (res_load) begin
      rem <= res.cnt;
    end else if (take) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      bytes <= res.bytes;
      fin   <= res.fin;
    end else if (take) begin
      bytes <= {8'h00, bytes[2:1]};
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> rem == 2'd0 || (rem == 2'd1 && take))
    else $error("results loaded over pending ones");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    take && rem == 2'd1 && !res_load |=> !out_valid)
    else $error("buffer not empty after last result");

endmodule

### test/tb_utf8_to_latin1_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_latin1_stream
// self-checking bench for the streaming UTF-8 to Latin-1 transcoder: a table
// of directed bytes, then random strings of mostly well-formed sequences,
// under several replacement byte settings, with random gaps and stalls on
// both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb_utf8_to_latin1_stream;
  import utf2l_pkg::*;

  localparam logic [ADDR_W-1:0] REPL_ADDR = {REG_REPLACEMENT, 2'b00};
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } latin_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       typed;
    logic       has_out;
    logic [7:0] out;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, is_final;
  logic [7:0] in_byte;
  logic out_valid, out_stall, run_last, text_end;
  logic [7:0] out_byte;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  // transcoder state as seen by the predictor
  logic [7:0]  repl_byte;
  logic [7:0]  pend_bytes [0:2];
  int unsigned pend_cnt;
  latin_t      decoded [0:2];

  latin_t     latin_q [$];
  logic [7:0] str_q [$];
  dir_row_t   dir_rows [$];
  int unsigned errors = 0;
  logic no_gaps = 1'b0;
  logic hold_off_req = 1'b0;

  utf8_to_latin1_stream DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .is_final(is_final),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .run_last(run_last), .text_end(text_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    if (c[7:5] == 3'b110) begin
      return LEN_TWO;
    end else if (c[7:4] == 4'b1110) begin
      return LEN_THREE;
    end else if (c[7:3] == 5'b11110) begin
      return LEN_FOUR;
    end
    return LEN_ONE;
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void add_str_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  // one accepted byte: hold it, or decode everything pending into decoded[]
  task automatic transcode_byte(input logic [7:0] b, input logic fin,
                                output int unsigned n);
    logic [7:0]  seq_bytes [0:3];
    logic [15:0] cp;
    logic [7:0]  c;
    int unsigned len, i, k, step;
    for (k = 0; k < pend_cnt; k++) seq_bytes[k] = pend_bytes[k];
    seq_bytes[pend_cnt] = b;
    len = pend_cnt + 1;
    n = 0;
    if (len < lead_len(seq_bytes[0]) && !fin) begin
      for (k = 0; k < len; k++) pend_bytes[k] = seq_bytes[k];
      pend_cnt = len;
      return;
    end
    i = 0;
    while (i < len && n < 3) begin
      c = seq_bytes[i];
      step = lead_len(c);
      cp = {8'h00, c};
      if (step > 1 && i + step <= len) begin
        case (step)
          LEN_TWO:   cp = {5'b0, c[4:0], seq_bytes[i+1][5:0]};
          LEN_THREE: cp = {c[3:0], seq_bytes[i+1][5:0], seq_bytes[i+2][5:0]};
          default:   cp = 16'h0100;
        endcase
      end else begin
        // truncated at the string end: the lead goes out raw
        step = 1;
      end
      decoded[n].data = (cp <= 16'h00ff) ? cp[7:0] : repl_byte;
      decoded[n].run_last = 1'b0;
      decoded[n].text_end = 1'b0;
      n++;
      i += step;
    end
    decoded[n-1].run_last = 1'b1;
    decoded[n-1].text_end = fin;
    pend_cnt = 0;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fin, input int typed_n,
                           input latin_t typed_res);
    int unsigned gap, n, k;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_byte = b;
    is_final = fin;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    transcode_byte(b, fin, n);
    if (typed_n >= 0) begin
      n = typed_n;
      decoded[0] = typed_res;
    end
    for (k = 0; k < n; k++) latin_q.insert(latin_q.size(), decoded[k]);
    @(negedge clk);
  endtask

  function automatic dir_row_t mk_row(input logic [7:0] data, input logic fin,
                                      input logic typed, input logic has_out,
                                      input logic [7:0] out);
    dir_row_t r;
    r.data = data;
    r.fin = fin;
    r.typed = typed;
    r.has_out = has_out;
    r.out = out;
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] v;
    // continuation bytes go unchecked, so now and then anything at all
    if ($urandom_range(0, 7) == 0) begin
      v = 8'($urandom_range(0, 255));
    end else begin
      v = 8'h80 | 8'($urandom_range(0, 63));
    end
    return v;
  endfunction

  task automatic build_string();
    int unsigned nchar, pick, need, ch, k;
    logic [7:0] lead;
    str_q.delete();
    nchar = $urandom_range(1, 6);
    for (ch = 0; ch < nchar; ch++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        add_str_byte(8'($urandom_range(0, 127)));
      end else if (pick < 75 || pick >= 85) begin
        if (pick < 50) begin
          // favor leads whose code point fits in Latin-1
          if ($urandom_range(0, 1)) lead = 8'hc0 | 8'($urandom_range(0, 3));
          else lead = 8'hc0 | 8'($urandom_range(0, 31));
        end else if (pick < 65) begin
          if ($urandom_range(0, 1)) lead = 8'he0;
          else lead = 8'he0 | 8'($urandom_range(0, 15));
        end else if (pick < 75) begin
          lead = 8'hf0 | 8'($urandom_range(0, 7));
        end else begin
          case ($urandom_range(0, 2))
            0: lead = 8'hc0 | 8'($urandom_range(0, 31));
            1: lead = 8'he0 | 8'($urandom_range(0, 15));
            default: lead = 8'hf0 | 8'($urandom_range(0, 7));
          endcase
        end
        need = lead_len(lead);
        // broken sequence: cut short before its last continuation
        if (pick >= 85) need = $urandom_range(1, need - 1);
        add_str_byte(lead);
        for (k = 1; k < need; k++) begin
          if (lead == 8'he0 && k == 1 && $urandom_range(0, 1))
            add_str_byte(8'h80 | 8'($urandom_range(0, 3)));
          else
            add_str_byte(cont_byte());
        end
      end else begin
        add_str_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent, k;
    sent = 0;
    while (sent < target) begin
      build_string();
      for (k = 0; k < str_q.size(); k++)
        send_byte(str_q[k], k == str_q.size() - 1, -1, '0);
      sent += str_q.size();
    end
    in_valid = 1'b0;
  endtask

  task automatic check_replacement();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = REPL_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== repl_byte) begin
      $display("%0t: replacement_byte read expected %h got %h", $time, repl_byte,
               prdata[7:0]);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_replacement(input logic [7:0] v);
    while (latin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = REPL_ADDR;
    pwdata = {24'h0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    repl_byte = v;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    check_replacement();
  endtask

  // receiver: random stall before each result, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin : drain_output
      int unsigned gap;
      @(negedge clk);
      if (hold_off_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    latin_t want;
    if (!rst && out_valid && !out_stall) begin
      if (latin_q.size() == 0) begin
        $display("%0t: unexpected result expected none got %h/%b/%b", $time,
                 out_byte, run_last, text_end);
        errors++;
      end else begin
        want = latin_q.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h got %h", $time, want.data, out_byte);
          errors++;
        end
        if (run_last !== want.run_last) begin
          $display("%0t: run_last expected %b got %b", $time, want.run_last, run_last);
          errors++;
        end
        if (text_end !== want.text_end) begin
          $display("%0t: text_end expected %b got %b", $time, want.text_end, text_end);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    latin_t typed_res;
    in_valid = 1'b0;
    in_byte = 8'h00;
    is_final = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repl_byte = REPLACEMENT_RESET;
    pend_cnt = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_replacement();

    // data, final, typed, has result, result
    add_row(mk_row(8'h00, 1'b0, 1'b1, 1'b1, 8'h00));
    add_row(mk_row(8'h7f, 1'b1, 1'b1, 1'b1, 8'h7f));
    add_row(mk_row(8'hff, 1'b0, 1'b1, 1'b1, 8'hff));
    add_row(mk_row(8'hf8, 1'b1, 1'b1, 1'b1, 8'hf8));
    // stray continuation
    add_row(mk_row(8'h80, 1'b0, 1'b1, 1'b1, 8'h80));
    // two-byte, fits
    add_row(mk_row(8'hc3, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'ha9, 1'b0, 1'b1, 1'b1, 8'he9));
    // two-byte, above 0xff
    add_row(mk_row(8'hc5, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'h93, 1'b0, 1'b1, 1'b1, REPLACEMENT_RESET));
    // three-byte, largest code point
    add_row(mk_row(8'hef, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'hbf, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'hbf, 1'b1, 1'b1, 1'b1, REPLACEMENT_RESET));
    // four-byte always replaced
    add_row(mk_row(8'hf0, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'h9f, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'h98, 1'b0, 1'b1, 1'b0, 8'h00));
    add_row(mk_row(8'h80, 1'b0, 1'b1, 1'b1, REPLACEMENT_RESET));
    // lead that is itself the last byte
    add_row(mk_row(8'hc2, 1'b1, 1'b1, 1'b1, 8'hc2));
    // flush: raw lead, then a complete two-byte sequence
    add_row(mk_row(8'hf0, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'hc3, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'ha9, 1'b1, 1'b0, 1'b0, 8'h00));
    // flush with three results, then a flush with two
    add_row(mk_row(8'hf7, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'h41, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'h42, 1'b1, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'he2, 1'b0, 1'b0, 1'b0, 8'h00));
    add_row(mk_row(8'h41, 1'b1, 1'b0, 1'b0, 8'h00));

    for (k = 0; k < dir_rows.size(); k++) begin
      typed_res.data = dir_rows[k].out;
      typed_res.run_last = 1'b1;
      typed_res.text_end = dir_rows[k].fin;
      send_byte(dir_rows[k].data, dir_rows[k].fin,
                dir_rows[k].typed ? int'(dir_rows[k].has_out) : -1, typed_res);
    end
    in_valid = 1'b0;

    set_replacement(8'h00);
    run_random(80);

    set_replacement(8'hff);
    hold_off_req = 1'b1;
    run_random(80);

    set_replacement(8'($urandom_range(1, 254)));
    no_gaps = 1'b1;
    run_random(80);
    no_gaps = 1'b0;

    set_replacement(REPLACEMENT_RESET);
    run_random(80);

    while (latin_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### utf8_to_latin1_stream.f
rtl/utf2l_pkg.sv
rtl/utf2l_cfg.sv
rtl/utf2l_decode.sv
rtl/utf2l_outbuf.sv
rtl/utf8_to_latin1_stream.sv
test/tb_utf8_to_latin1_stream.sv
